@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SSTF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// When ante holds, cons must hold on the following edge.
`define SSTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sstf_pkg.sv @@
`timescale 1ns / 1ps

package sstf_pkg;

   localparam int POS_FIELD_W   = 16;
   localparam int TOTAL_FIELD_W = 21;
   localparam logic [POS_FIELD_W-1:0]   DIST_MAX  = 16'hFFFF;
   localparam logic [TOTAL_FIELD_W-1:0] TOTAL_MAX = 21'h1FFFFF;

   typedef enum logic [2:0] {
      STEP_LOAD   = 3'd0,
      STEP_INIT   = 3'd1,
      STEP_SCAN   = 3'd2,
      STEP_EMIT   = 3'd3,
      STEP_FINISH = 3'd4
   } step_type;

   // condition that lets the sequencer leave the current step
   typedef enum logic [1:0] {
      GO_ALWAYS      = 2'd0,
      GO_LAST_ACCEPT = 2'd1,
      GO_SCAN_DONE   = 2'd2,
      GO_OUT_FREE    = 2'd3
   } go_type;

   // once leaving: jump to target when true, else fall through to next step
   typedef enum logic [1:0] {
      BR_NEVER    = 2'd0,
      BR_ALWAYS   = 2'd1,
      BR_NOT_LAST = 2'd2
   } br_type;

   typedef struct packed {
      logic     req_ready;
      logic     load;
      logic     init;
      logic     scan;
      logic     emit;
      logic     finish;
      go_type   go;
      br_type   br;
      step_type target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '0;
      case (step)
         STEP_LOAD: begin
            w.req_ready = 1'b1;
            w.load      = 1'b1;
            w.go        = GO_LAST_ACCEPT;
            w.br        = BR_NEVER;
            w.target    = STEP_LOAD;
         end
         STEP_INIT: begin
            w.init   = 1'b1;
            w.go     = GO_ALWAYS;
            w.br     = BR_NEVER;
            w.target = STEP_LOAD;
         end
         STEP_SCAN: begin
            w.scan   = 1'b1;
            w.go     = GO_SCAN_DONE;
            w.br     = BR_NEVER;
            w.target = STEP_LOAD;
         end
         STEP_EMIT: begin
            w.emit   = 1'b1;
            w.go     = GO_OUT_FREE;
            w.br     = BR_NOT_LAST;
            w.target = STEP_SCAN;
         end
         STEP_FINISH: begin
            w.finish = 1'b1;
            w.go     = GO_ALWAYS;
            w.br     = BR_ALWAYS;
            w.target = STEP_LOAD;
         end
         default: begin
            w.go     = GO_ALWAYS;
            w.br     = BR_ALWAYS;
            w.target = STEP_LOAD;
         end
      endcase
      return w;
   endfunction

endpackage

@@ sv/sstf_if.sv @@
`timescale 1ns / 1ps

interface sstf_req_if;
   logic                               valid;
   logic                               ready;
   logic [sstf_pkg::POS_FIELD_W-1:0]   request_position;
   logic                               last_request;

   modport source (output valid, output request_position, output last_request, input ready);
   modport sink (input valid, input request_position, input last_request, output ready);
endinterface

interface sstf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sstf_pkg::POS_FIELD_W-1:0]   served_position;
   logic [sstf_pkg::POS_FIELD_W-1:0]   seek_distance;
   logic [sstf_pkg::TOTAL_FIELD_W-1:0] total_movement;
   logic                               last_served;

   modport source (output valid, output served_position, output seek_distance,
                   output total_movement, output last_served, input ready);
   modport sink (input valid, input served_position, input seek_distance,
                 input total_movement, input last_served, output ready);
endinterface

@@ sv/sstf_seek_scheduler_top.sv @@
`timescale 1ns / 1ps
// Shortest-seek-first disk request scheduler.
// req_if carries request words (position, last flag); rsp_if returns one word
// per served request (position, seek distance, running total, last flag).
// csr_write_en/csr_write_data set the start head; the user must write it only
// while idle; the block does not enforce this. Loading: one request word per
// cycle; words beyond QUEUE_DEPTH are dropped. The word flagged last closes
// the batch and starts serving; req_if.ready stays low until the whole batch
// has been handed to the output register. Serving a batch: a setup step, then
// per result a scan over the request RAM (one read per cycle) and an emit
// step; a cleanup step follows the final result.
// A one-deep output register holds a result while rsp_if.ready is low; the
// sequencer waits in its emit step until the register frees up. The last
// result may still wait there while the next batch loads.
// Reset (synchronous) empties the queue, zeroes the start head and drops
// any pending result. The request RAM is not cleared; only loaded entries
// are evaluated.
`include "assert_macros.svh"

module sstf_seek_scheduler_top #(
   parameter int QUEUE_DEPTH   = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [sstf_pkg::POS_FIELD_W-1:0] csr_write_data,
   sstf_req_if.sink                         req_if,
   sstf_rsp_if.source                       rsp_if
);

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int HEAD_W = (POSITION_BITS > sstf_pkg::POS_FIELD_W) ?
                           POSITION_BITS : sstf_pkg::POS_FIELD_W;
   localparam int SUM_W  = HEAD_W + CNT_W;
   localparam int TOT_W  = (SUM_W > sstf_pkg::TOTAL_FIELD_W) ?
                           SUM_W : sstf_pkg::TOTAL_FIELD_W;

   sstf_pkg::step_type      step_ff, step_in;
   sstf_pkg::ctrl_word_type ctrl;

   logic [sstf_pkg::POS_FIELD_W-1:0] start_head_ff, start_head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [CNT_W-1:0]         served_cnt_ff, served_cnt_in;
   logic [QUEUE_DEPTH-1:0]   flags_ff, flags_in;
   logic [HEAD_W-1:0]        head_ff, head_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic                     found_ff, found_in;
   logic [HEAD_W-1:0]        best_ff, best_in;
   logic [IDX_W-1:0]         pick_ff, pick_in;
   logic [HEAD_W-1:0]        pick_pos_ff, pick_pos_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [sstf_pkg::POS_FIELD_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [sstf_pkg::POS_FIELD_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic [sstf_pkg::TOTAL_FIELD_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic                     ram_we;
   logic [HEAD_W-1:0]        req_pos_ext;
   logic [POSITION_BITS-1:0] ram_rd_data;
   logic [HEAD_W-1:0]        cand_pos;
   logic [HEAD_W-1:0]        cand_dist;
   logic [IDX_W-1:0]         eval_idx;
   logic                     take;
   logic                     scan_done;
   logic                     out_free;
   logic                     emit_fire;
   logic                     batch_last;
   logic [CNT_W-1:0]         served_next;
   logic [SUM_W-1:0]         new_sum;
   logic [TOT_W-1:0]         total_wide;
   logic                     go;
   logic                     br;

   // ---------------- control word decode ----------------
   always_comb begin
      ctrl         = sstf_pkg::ucode_rom(step_ff);
      req_if.ready = ctrl.req_ready;
   end

   assign accept      = req_if.valid && req_if.ready;
   assign scan_done   = (scan_ff == count_ff);
   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign emit_fire   = ctrl.emit && out_free;
   assign served_next = served_cnt_ff + CNT_W'(1);
   assign batch_last  = (served_next == count_ff);

   // ---------------- sequencer ----------------
   always_comb begin
      case (ctrl.go)
         sstf_pkg::GO_ALWAYS:      go = 1'b1;
         sstf_pkg::GO_LAST_ACCEPT: go = accept && req_if.last_request;
         sstf_pkg::GO_SCAN_DONE:   go = scan_done;
         sstf_pkg::GO_OUT_FREE:    go = out_free;
         default:                  go = 1'b0;
      endcase
      case (ctrl.br)
         sstf_pkg::BR_NEVER:    br = 1'b0;
         sstf_pkg::BR_ALWAYS:   br = 1'b1;
         sstf_pkg::BR_NOT_LAST: br = !batch_last;
         default:               br = 1'b0;
      endcase
      step_in = step_ff;
      if (go) begin
         if (br) begin
            step_in = ctrl.target;
         end else begin
            step_in = sstf_pkg::step_type'(step_ff + 3'd1);
         end
      end
   end

   // ---------------- request store ----------------
   assign req_pos_ext = HEAD_W'(req_if.request_position);
   assign ram_we      = ctrl.load && accept && (count_ff < CNT_W'(QUEUE_DEPTH));

   sstf_ram #(
      .WIDTH (POSITION_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_pos_ext[POSITION_BITS-1:0]),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // read data is registered: it belongs to the entry addressed in the previous cycle
   assign cand_pos  = HEAD_W'(ram_rd_data);
   assign cand_dist = (head_ff >= cand_pos) ? (head_ff - cand_pos) : (cand_pos - head_ff);
   assign eval_idx  = IDX_W'(scan_ff - CNT_W'(1));
   // strict less-than keeps the earliest loaded entry on a tie
   assign take      = ctrl.scan && (scan_ff != '0) && !flags_ff[eval_idx] &&
                      (!found_ff || (cand_dist < best_ff));

   assign new_sum    = sum_ff + SUM_W'(best_ff);
   assign total_wide = TOT_W'(new_sum);

   // ---------------- datapath next values ----------------
   always_comb begin
      start_head_in = start_head_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      served_cnt_in = served_cnt_ff;
      flags_in      = flags_ff;
      head_in       = head_ff;
      sum_in        = sum_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      pick_pos_in   = pick_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_write_en) begin
         start_head_in = csr_write_data;
      end

      if (ram_we) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (ctrl.init) begin
         head_in       = HEAD_W'(start_head_ff);
         sum_in        = '0;
         flags_in      = '0;
         served_cnt_in = '0;
         scan_in       = '0;
         found_in      = 1'b0;
      end

      if (ctrl.scan) begin
         if (!scan_done) begin
            scan_in = scan_ff + CNT_W'(1);
         end
         if (take) begin
            found_in    = 1'b1;
            best_in     = cand_dist;
            pick_in     = eval_idx;
            pick_pos_in = cand_pos;
         end
      end

      if (emit_fire) begin
         rsp_valid_in            = 1'b1;
         rsp_pos_in              = pick_pos_ff[sstf_pkg::POS_FIELD_W-1:0];
         rsp_dist_in             = (best_ff > HEAD_W'(sstf_pkg::DIST_MAX)) ?
                                   sstf_pkg::DIST_MAX :
                                   best_ff[sstf_pkg::POS_FIELD_W-1:0];
         rsp_total_in            = (total_wide > TOT_W'(sstf_pkg::TOTAL_MAX)) ?
                                   sstf_pkg::TOTAL_MAX :
                                   total_wide[sstf_pkg::TOTAL_FIELD_W-1:0];
         rsp_last_in             = batch_last;
         head_in                 = pick_pos_ff;
         sum_in                  = new_sum;
         flags_in[pick_ff]       = 1'b1;
         served_cnt_in           = served_next;
         scan_in                 = '0;
         found_in                = 1'b0;
      end

      if (ctrl.finish) begin
         count_in = '0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= sstf_pkg::STEP_LOAD;
         start_head_ff <= '0;
         count_ff      <= '0;
         scan_ff       <= '0;
         served_cnt_ff <= '0;
         flags_ff      <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         start_head_ff <= start_head_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         served_cnt_ff <= served_cnt_in;
         flags_ff      <= flags_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      sum_ff       <= sum_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      pick_pos_ff  <= pick_pos_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.served_position = rsp_pos_ff;
   assign rsp_if.seek_distance   = rsp_dist_ff;
   assign rsp_if.total_movement  = rsp_total_ff;
   assign rsp_if.last_served     = rsp_last_ff;

   // ---------------- assertions ----------------
   `SSTF_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count past depth")
   `SSTF_ASSERT(a_emit_found, clock, reset, (step_ff == sstf_pkg::STEP_EMIT) |-> found_ff, "emit without a candidate")
   `SSTF_ASSERT(a_emit_count, clock, reset, (step_ff == sstf_pkg::STEP_EMIT) |-> (served_cnt_ff < count_ff), "serving past batch size")
   `SSTF_ASSERT(a_scan_bound, clock, reset, (step_ff == sstf_pkg::STEP_SCAN) |-> (scan_ff <= count_ff), "scan index overran batch")
   `SSTF_ASSERT_NEXT(a_last_finish, clock, reset, emit_fire && batch_last, step_ff == sstf_pkg::STEP_FINISH, "final result not followed by cleanup")

endmodule

@@ sv/sstf_ram.sv @@
`timescale 1ns / 1ps

module sstf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
